/* sv/msca_pkg.sv */
// Shared types, constants and sine tables for the sine color animator.
`default_nettype none

package msca_pkg;

   // Geometry
   localparam int FIBER_COUNT    = 16;
   localparam int PHASE_BITS     = 32;
   localparam int SINE_ADDR_BITS = 10;

   localparam int CHAN_TOTAL = 3 * FIBER_COUNT;
   localparam int CHAN_W     = $clog2(CHAN_TOTAL);
   localparam int FIB_W      = (FIBER_COUNT > 1) ? $clog2(FIBER_COUNT) : 1;

   // Field widths
   localparam int FIBER_BITS     = 4;
   localparam int COLOR_BITS     = 2;
   localparam int START_BITS     = 32;
   localparam int RATE_BITS      = 20;
   localparam int MS_BITS        = 16;
   localparam int GAIN_BITS      = 16;
   localparam int LEVEL_BITS     = 8;
   localparam int OUT_FIBER_BITS = 4;

   // Configuration port
   localparam int CSR_COUNT      = 7;
   localparam int CSR_INDEX_BITS = $clog2(CSR_COUNT);
   localparam int CSR_DATA_BITS  = GAIN_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPEED_GAIN = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RED_MIN    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RED_MAX    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GREEN_MIN  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GREEN_MAX  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLUE_MIN   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLUE_MAX   = 3'd6;

   localparam logic [GAIN_BITS-1:0]  GAIN_RESET      = 16'd256;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MIN_RESET = 8'd0;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX_RESET = 8'd255;

   // Request function codes
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   // Color channel codes
   localparam logic [COLOR_BITS-1:0] COLOR_RED     = 2'd0;
   localparam logic [COLOR_BITS-1:0] COLOR_GREEN   = 2'd1;
   localparam logic [COLOR_BITS-1:0] COLOR_BLUE    = 2'd2;
   localparam logic [COLOR_BITS-1:0] COLOR_INVALID = 2'd3;

   // Digit-serial multiplier: multiplicand is gain*ms wide, multiplier is a rate
   localparam int DIGIT_BITS  = 4;
   localparam int MCAND_BITS  = GAIN_BITS + MS_BITS;
   localparam int SUM_BITS    = MCAND_BITS + DIGIT_BITS;
   localparam int PROD_BITS   = MCAND_BITS + RATE_BITS;
   localparam int MUL_STEPS   = RATE_BITS / DIGIT_BITS;
   localparam int STEP_W      = $clog2(MUL_STEPS);
   localparam int ADV_SHIFT   = 8;

   // Phase store word: {rate, phase}
   localparam int ENTRY_BITS = RATE_BITS + PHASE_BITS;

   // Sine table, quarter wave plus end point, upper and lower half
   localparam int QTR_W           = SINE_ADDR_BITS - 2;
   localparam int QUARTER         = 1 << QTR_W;
   localparam int QUARTER_ENTRIES = QUARTER + 1;
   localparam logic [QTR_W:0]  QUARTER_IDX = QTR_W'(0) + (QTR_W+1)'(QUARTER);
   localparam logic [63:0]     ONE_Q28     = 64'd1 << 28;
   localparam logic [63:0]     HALF_PI_Q28 = 64'd421657428;

   typedef struct packed {
      logic                    func;
      logic [FIBER_BITS-1:0]   fiber_index;
      logic [COLOR_BITS-1:0]   color_channel;
      logic [START_BITS-1:0]   start_phase;
      logic [RATE_BITS-1:0]    turn_rate;
      logic [MS_BITS-1:0]      elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [OUT_FIBER_BITS-1:0] out_fiber;
      logic [LEVEL_BITS-1:0]     red_level;
      logic [LEVEL_BITS-1:0]     green_level;
      logic [LEVEL_BITS-1:0]     blue_level;
      logic                      last_fiber;
   } rsp_type;

   // Quarter-wave sine in unsigned Q28, Taylor series to x^11 (elaboration only)
   function automatic logic [63:0] quarter_sin(input logic [31:0] q);
      logic [63:0] x, x2, t, pos, neg, s;
      x   = (64'(q) * HALF_PI_Q28) / QUARTER;
      x2  = (x * x) >> 28;
      t   = ((x * x2) >> 28) / 64'd6;
      neg = t;
      t   = ((t * x2) >> 28) / 64'd20;
      pos = x + t;
      t   = ((t * x2) >> 28) / 64'd42;
      neg = neg + t;
      t   = ((t * x2) >> 28) / 64'd72;
      pos = pos + t;
      t   = ((t * x2) >> 28) / 64'd110;
      neg = neg + t;
      s   = (pos > neg) ? pos - neg : 64'd0;
      return (s > ONE_Q28) ? ONE_Q28 : s;
   endfunction

   function automatic logic [8*QUARTER_ENTRIES-1:0] build_quarter_rom(input logic lower);
      logic [8*QUARTER_ENTRIES-1:0] rom;
      logic [63:0] s, base, v;
      rom = '0;
      for (int q = 0; q < QUARTER_ENTRIES; q++) begin
         s    = quarter_sin(32'(q));
         base = lower ? ONE_Q28 - s : ONE_Q28 + s;
         v    = (64'd255 * base + ONE_Q28) >> 29;
         rom[8*q +: 8] = (v > 64'd255) ? 8'd255 : v[7:0];
      end
      return rom;
   endfunction

   localparam logic [8*QUARTER_ENTRIES-1:0] SINE_HIGH_ROM = build_quarter_rom(1'b0);
   localparam logic [8*QUARTER_ENTRIES-1:0] SINE_LOW_ROM  = build_quarter_rom(1'b1);

   // Full-wave level from the top phase bits, by quadrant symmetry
   function automatic logic [LEVEL_BITS-1:0] sine_level(input logic [SINE_ADDR_BITS-1:0] k);
      logic [1:0]     quad;
      logic [QTR_W:0] r;
      logic [QTR_W:0] q;
      quad = k[SINE_ADDR_BITS-1 -: 2];
      r    = {1'b0, k[QTR_W-1:0]};
      q    = quad[0] ? QUARTER_IDX - r : r;
      return quad[1] ? SINE_LOW_ROM[8*q +: 8] : SINE_HIGH_ROM[8*q +: 8];
   endfunction

endpackage

`default_nettype wire

/* sv/multichannel_sine_color_animator_top.sv */
// Top level of the multichannel sine color animator.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_data): a load request
//    (func = load) sets the start phase and turn rate of one color channel of
//    one fiber and gives no result. A tick request
//    (func = tick) advances all 3*FIBER_COUNT phases by
//    (rate * speed_gain * elapsed_ms) >> 8 and then gives one result per fiber.
//  - Result channel (rsp_valid / rsp_stall / rsp_data): fibers in order, with
//    last_fiber set on the final one. Results leave through an output register.
//  - Config port (csr_we / csr_index / csr_wdata): write only while idle.
// Sequence: a tick runs a 4-bit digit-serial multiplier, 5 steps for gain*ms,
//   then per channel: store read, load, 5 multiply steps, write-back, sine
//   table, blend multiply, level; then per fiber a result emit. The shared
//   multiplier handles one channel at a time. req_stall stays high while a
//   tick is in progress.
// Reset: config registers return to their defaults and all phases and rates
//   read as zero (per-entry valid bits clear at once, no sweep).
// Stall: a stalled result holds in the output register; the walk waits at
//   the next fiber until the register frees up.
`default_nettype none

module multichannel_sine_color_animator_top
   import msca_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire req_type                   req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      rsp_type                   rsp_data,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_KMUL  = 10'b0000000010,
      S_READ  = 10'b0000000100,
      S_LOAD  = 10'b0000001000,
      S_MUL   = 10'b0000010000,
      S_SUM   = 10'b0000100000,
      S_SINE  = 10'b0001000000,
      S_BLEND = 10'b0010000000,
      S_LEVEL = 10'b0100000000,
      S_EMIT  = 10'b1000000000
   } state_type;

   // Control state
   state_type               state_ff, state_in;
   logic [CHAN_W-1:0]       chan_ff, chan_in;
   logic [COLOR_BITS-1:0]   color_ff, color_in;
   logic [FIB_W-1:0]        fiber_ff, fiber_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAN_TOTAL-1:0]   valid_ff, valid_in;

   // Config registers
   logic [GAIN_BITS-1:0]    gain_ff, gain_in;
   logic [LEVEL_BITS-1:0]   rmin_ff, rmin_in, rmax_ff, rmax_in;
   logic [LEVEL_BITS-1:0]   gmin_ff, gmin_in, gmax_ff, gmax_in;
   logic [LEVEL_BITS-1:0]   bmin_ff, bmin_in, bmax_ff, bmax_in;

   // Datapath
   logic [MCAND_BITS-1:0]   mcand_ff, mcand_in;
   logic [RATE_BITS-1:0]    mplier_ff, mplier_in;
   logic [MCAND_BITS-1:0]   hi_ff, hi_in;
   logic [RATE_BITS-1:0]    lo_ff, lo_in;
   logic [MCAND_BITS-1:0]   k_ff, k_in;
   logic [PHASE_BITS-1:0]   phase_ff, phase_in;
   logic [RATE_BITS-1:0]    rate_ff, rate_in;
   logic [LEVEL_BITS-1:0]   sine_ff, sine_in;
   logic [15:0]             prod_ff, prod_in;
   logic [LEVEL_BITS-1:0]   base_ff, base_in;
   logic                    down_ff, down_in;
   logic [LEVEL_BITS-1:0]   red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   // Phase/rate store
   logic [ENTRY_BITS-1:0]   store_mem [CHAN_TOTAL];
   logic [ENTRY_BITS-1:0]   rd_word_ff;
   logic                    rd_valid_ff;
   logic                    mem_we;
   logic [CHAN_W-1:0]       mem_waddr;
   logic [ENTRY_BITS-1:0]   mem_wdata;

   // Combinational helpers
   logic                    req_accept;
   logic                    load_ok;
   logic [CHAN_W-1:0]       load_addr;
   logic [DIGIT_BITS-1:0]   digit;
   logic [SUM_BITS-1:0]     mul_part;
   logic [SUM_BITS-1:0]     mul_sum;
   logic [MCAND_BITS-1:0]   hi_step;
   logic [RATE_BITS-1:0]    lo_step;
   logic [PROD_BITS-1:0]    prod_full;
   logic [PROD_BITS-1:0]    prod_next;
   logic [PHASE_BITS-1:0]   adv;
   logic                    last_step;
   logic [LEVEL_BITS-1:0]   sel_min, sel_max;
   logic [LEVEL_BITS-1:0]   diff;
   logic [16:0]             quot_sum;
   logic [LEVEL_BITS-1:0]   quot;
   logic [LEVEL_BITS-1:0]   level;
   logic                    emit_go;
   logic                    last_fib;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign load_ok   = (req_data.color_channel != COLOR_INVALID) &&
                      (int'(req_data.fiber_index) < FIBER_COUNT);
   assign load_addr = CHAN_W'(3 * int'(req_data.fiber_index) + int'(req_data.color_channel));

   // One 4-bit digit of the multiplier per step, LSB first; the product
   // leaves the bottom of hi into lo.
   assign digit     = mplier_ff[DIGIT_BITS-1:0];
   assign mul_part  = SUM_BITS'(mcand_ff) * SUM_BITS'(digit);
   assign mul_sum   = SUM_BITS'(hi_ff) + mul_part;
   assign hi_step   = mul_sum[SUM_BITS-1:DIGIT_BITS];
   assign lo_step   = {mul_sum[DIGIT_BITS-1:0], lo_ff[RATE_BITS-1:DIGIT_BITS]};
   assign prod_full = {hi_ff, lo_ff};
   assign prod_next = {hi_step, lo_step};
   assign adv       = prod_full[PHASE_BITS+ADV_SHIFT-1:ADV_SHIFT];
   assign last_step = (step_ff == STEP_W'(MUL_STEPS - 1));

   // x / 255 for 16-bit x: (x + (x >> 8) + 1) >> 8
   assign quot_sum = 17'(prod_ff) + 17'(prod_ff[15:8]) + 17'd1;
   assign quot     = quot_sum[15:8];
   assign level    = down_ff ? base_ff - quot : base_ff + quot;

   assign emit_go  = !rsp_valid_ff || !rsp_stall;
   assign last_fib = (fiber_ff == FIB_W'(FIBER_COUNT - 1));

   always_comb begin
      unique case (color_ff)
         COLOR_RED: begin
            sel_min = rmin_ff;
            sel_max = rmax_ff;
         end
         COLOR_GREEN: begin
            sel_min = gmin_ff;
            sel_max = gmax_ff;
         end
         default: begin
            sel_min = bmin_ff;
            sel_max = bmax_ff;
         end
      endcase
   end

   assign diff = (sel_max < sel_min) ? sel_min - sel_max : sel_max - sel_min;

   // Config decode
   always_comb begin
      gain_in = gain_ff;
      rmin_in = rmin_ff;
      rmax_in = rmax_ff;
      gmin_in = gmin_ff;
      gmax_in = gmax_ff;
      bmin_in = bmin_ff;
      bmax_in = bmax_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED_GAIN: gain_in = csr_wdata;
            CSR_RED_MIN:    rmin_in = csr_wdata[LEVEL_BITS-1:0];
            CSR_RED_MAX:    rmax_in = csr_wdata[LEVEL_BITS-1:0];
            CSR_GREEN_MIN:  gmin_in = csr_wdata[LEVEL_BITS-1:0];
            CSR_GREEN_MAX:  gmax_in = csr_wdata[LEVEL_BITS-1:0];
            CSR_BLUE_MIN:   bmin_in = csr_wdata[LEVEL_BITS-1:0];
            CSR_BLUE_MAX:   bmax_in = csr_wdata[LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      color_in     = color_ff;
      fiber_in     = fiber_ff;
      step_in      = step_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      k_in         = k_ff;
      phase_in     = phase_ff;
      rate_in      = rate_ff;
      sine_in      = sine_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      down_in      = down_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = load_addr;
      mem_wdata    = {req_data.turn_rate, PHASE_BITS'(req_data.start_phase)};

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_data.func == FUNC_LOAD) begin
                  mem_we = load_ok;
               end else begin
                  // gain * ms through the same multiplier
                  mcand_in  = MCAND_BITS'(gain_ff);
                  mplier_in = RATE_BITS'(req_data.elapsed_ms);
                  hi_in     = '0;
                  lo_in     = '0;
                  step_in   = '0;
                  chan_in   = '0;
                  color_in  = COLOR_RED;
                  fiber_in  = '0;
                  state_in  = S_KMUL;
               end
            end
         end
         S_KMUL: begin
            hi_in     = hi_step;
            lo_in     = lo_step;
            mplier_in = mplier_ff >> DIGIT_BITS;
            step_in   = step_ff + STEP_W'(1);
            if (last_step) begin
               k_in     = prod_next[MCAND_BITS-1:0];
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // never-loaded entries read as zero
            rate_in   = rd_valid_ff ? rd_word_ff[ENTRY_BITS-1:PHASE_BITS] : '0;
            phase_in  = rd_valid_ff ? rd_word_ff[PHASE_BITS-1:0] : '0;
            mplier_in = rd_valid_ff ? rd_word_ff[ENTRY_BITS-1:PHASE_BITS] : '0;
            mcand_in  = k_ff;
            hi_in     = '0;
            lo_in     = '0;
            step_in   = '0;
            state_in  = S_MUL;
         end
         S_MUL: begin
            hi_in     = hi_step;
            lo_in     = lo_step;
            mplier_in = mplier_ff >> DIGIT_BITS;
            step_in   = step_ff + STEP_W'(1);
            if (last_step) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            phase_in  = phase_ff + adv;
            mem_we    = 1'b1;
            mem_waddr = chan_ff;
            mem_wdata = {rate_ff, phase_ff + adv};
            state_in  = S_SINE;
         end
         S_SINE: begin
            sine_in  = sine_level(phase_ff[PHASE_BITS-1 -: SINE_ADDR_BITS]);
            state_in = S_BLEND;
         end
         S_BLEND: begin
            prod_in  = 16'(diff) * 16'(sine_ff);
            base_in  = sel_min;
            down_in  = (sel_max < sel_min);
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            case (color_ff)
               COLOR_RED:   red_in   = level;
               COLOR_GREEN: green_in = level;
               default:     blue_in  = level;
            endcase
            if (color_ff == COLOR_BLUE) begin
               state_in = S_EMIT;
            end else begin
               color_in = color_ff + COLOR_BITS'(1);
               chan_in  = chan_ff + CHAN_W'(1);
               state_in = S_READ;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_fiber   = OUT_FIBER_BITS'(fiber_ff);
               rsp_data_in.red_level   = red_ff;
               rsp_data_in.green_level = green_ff;
               rsp_data_in.blue_level  = blue_ff;
               rsp_data_in.last_fiber  = last_fib;
               if (last_fib) begin
                  state_in = S_IDLE;
               end else begin
                  fiber_in = fiber_ff + FIB_W'(1);
                  color_in = COLOR_RED;
                  chan_in  = chan_ff + CHAN_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_ff      <= '0;
         color_ff     <= COLOR_RED;
         fiber_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         gain_ff      <= GAIN_RESET;
         rmin_ff      <= LEVEL_MIN_RESET;
         rmax_ff      <= LEVEL_MAX_RESET;
         gmin_ff      <= LEVEL_MIN_RESET;
         gmax_ff      <= LEVEL_MAX_RESET;
         bmin_ff      <= LEVEL_MIN_RESET;
         bmax_ff      <= LEVEL_MAX_RESET;
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         color_ff     <= color_in;
         fiber_ff     <= fiber_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         gain_ff      <= gain_in;
         rmin_ff      <= rmin_in;
         rmax_ff      <= rmax_in;
         gmin_ff      <= gmin_in;
         gmax_ff      <= gmax_in;
         bmin_ff      <= bmin_in;
         bmax_ff      <= bmax_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      k_ff        <= k_in;
      phase_ff    <= phase_in;
      rate_ff     <= rate_in;
      sine_ff     <= sine_in;
      prod_ff     <= prod_in;
      base_ff     <= base_in;
      down_ff     <= down_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff  <= store_mem[chan_ff];
      rd_valid_ff <= valid_ff[chan_ff];
   end

`ifndef ASSERT_OFF
   a_chan_tracks_fiber: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |->
         (chan_ff == CHAN_W'(3 * int'(fiber_ff) + int'(color_ff))))
      else $error("channel address out of step with fiber/color");

   a_emit_after_blue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (color_ff == COLOR_BLUE))
      else $error("fiber result issued before all three colors");

   a_no_result_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && rsp_valid_ff && rsp_stall) |=>
         (state_ff == S_EMIT && rsp_valid_ff))
      else $error("pending result overwritten or fiber skipped");

   a_tick_starts_gain: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.func == FUNC_TICK) |=> (state_ff == S_KMUL))
      else $error("tick request did not start the gain multiply");
`endif

endmodule

`default_nettype wire
